[rtl/four_register_cpu_step_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the CPU step unit
// Checks are sampled on i_clk; FRCS_CHECK is switched off while reset is applied, FRCS_CHECK_ALWAYS is not.
// ----------------------------------------------------------------------------
`ifndef FOUR_REGISTER_CPU_STEP_UNIT_MACROS_SVH
`define FOUR_REGISTER_CPU_STEP_UNIT_MACROS_SVH

// Check a property while reset is released.
`define FRCS_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define FRCS_CHECK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/frcs_pkg.sv]
// ----------------------------------------------------------------------------
// frcs_pkg
// Opcodes, ALU operation codes and decode helpers for the CPU step unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package frcs_pkg;

    localparam int unsigned MEM_WORDS = 256;
    localparam int unsigned ADDR_W    = 8;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned SP_W      = 9;
    localparam int unsigned COST_W    = 5;

    localparam logic [4:0] OP_LD   = 5'd0;
    localparam logic [4:0] OP_ST   = 5'd1;
    localparam logic [4:0] OP_ADD  = 5'd2;
    localparam logic [4:0] OP_ADC  = 5'd3;
    localparam logic [4:0] OP_SUB  = 5'd4;
    localparam logic [4:0] OP_SBC  = 5'd5;
    localparam logic [4:0] OP_AND  = 5'd6;
    localparam logic [4:0] OP_XOR  = 5'd7;
    localparam logic [4:0] OP_NOT  = 5'd8;
    localparam logic [4:0] OP_SHL  = 5'd9;
    localparam logic [4:0] OP_ASR  = 5'd11;
    localparam logic [4:0] OP_CMP  = 5'd13;
    localparam logic [4:0] OP_GST  = 5'd14;
    localparam logic [4:0] OP_PST  = 5'd15;
    localparam logic [4:0] OP_JMP  = 5'd16;
    localparam logic [4:0] OP_JLT  = 5'd17;
    localparam logic [4:0] OP_JEQ  = 5'd18;
    localparam logic [4:0] OP_JGT  = 5'd19;
    localparam logic [4:0] OP_CALL = 5'd20;
    localparam logic [4:0] OP_RET  = 5'd21;
    localparam logic [4:0] OP_RD   = 5'd22;
    localparam logic [4:0] OP_WR   = 5'd23;
    localparam logic [4:0] OP_HALT = 5'd24;
    localparam logic [4:0] OP_NOP  = 5'd25;

    localparam logic [COST_W-1:0] COST_ONE  = 5'd1;
    localparam logic [COST_W-1:0] COST_MEM  = 5'd4;
    localparam logic [COST_W-1:0] COST_IO   = 5'd28;
    localparam logic [COST_W-1:0] COST_NONE = 5'd0;

    typedef enum logic [3:0] {
        ALU_ADD, ALU_ADC, ALU_SUB, ALU_SBC, ALU_AND,
        ALU_XOR, ALU_NOT, ALU_SHL, ALU_ASR
    } t_alu_op;

    typedef struct packed {
        logic lt;
        logic eq;
        logic gt;
    } t_cmp_flags;

    function automatic logic op_known(input logic [4:0] op);
        op_known = (op <= OP_SHL) || (op == OP_ASR) || ((op >= OP_CMP) && (op <= OP_NOP));
    endfunction

    function automatic logic [COST_W-1:0] op_cost(input logic [4:0] op, input logic imm);
        unique case (op)
            OP_LD:                  op_cost = imm ? COST_ONE : COST_MEM;
            OP_ST, OP_CALL, OP_RET: op_cost = COST_MEM;
            OP_RD, OP_WR:           op_cost = COST_IO;
            OP_NOP:                 op_cost = COST_NONE;
            default:                op_cost = COST_ONE;
        endcase
    endfunction

    function automatic t_alu_op alu_sel(input logic [4:0] op);
        unique case (op)
            OP_ADC:  alu_sel = ALU_ADC;
            OP_SUB:  alu_sel = ALU_SUB;
            OP_SBC:  alu_sel = ALU_SBC;
            OP_AND:  alu_sel = ALU_AND;
            OP_XOR:  alu_sel = ALU_XOR;
            OP_NOT:  alu_sel = ALU_NOT;
            OP_SHL:  alu_sel = ALU_SHL;
            OP_ASR:  alu_sel = ALU_ASR;
            default: alu_sel = ALU_ADD;
        endcase
    endfunction

endpackage

`default_nettype wire

[rtl/frcs_ram.sv]
// ----------------------------------------------------------------------------
// frcs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frcs_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/frcs_alu.sv]
// ----------------------------------------------------------------------------
// frcs_alu
// Shared arithmetic, logic, shift and signed compare unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frcs_alu
    import frcs_pkg::*;
(
    input  wire t_alu_op           i_op,
    input  wire logic [WORD_W-1:0] i_a,
    input  wire logic [WORD_W-1:0] i_b,
    input  wire logic              i_carry,
    output      logic [WORD_W-1:0] o_y,
    output      t_cmp_flags        o_cmp
);

    logic [WORD_W-1:0] carry_ext;

    assign carry_ext = {{(WORD_W-1){1'b0}}, i_carry};

    always_comb begin
        unique case (i_op)
            ALU_ADD: o_y = i_a + i_b;
            ALU_ADC: o_y = i_a + i_b + carry_ext;
            ALU_SUB: o_y = i_a - i_b;
            ALU_SBC: o_y = i_a - i_b - carry_ext;
            ALU_AND: o_y = i_a & i_b;
            ALU_XOR: o_y = i_a ^ i_b;
            ALU_NOT: o_y = ~i_a;
            ALU_SHL: o_y = {i_a[WORD_W-2:0], 1'b0};
            ALU_ASR: o_y = {i_a[WORD_W-1], i_a[WORD_W-1:1]};
            default: o_y = i_a;
        endcase
    end

    // Signed compare of a against b
    assign o_cmp.lt = $signed(i_a) < $signed(i_b);
    assign o_cmp.eq = i_a == i_b;
    assign o_cmp.gt = $signed(i_a) > $signed(i_b);

endmodule

`default_nettype wire

[rtl/four_register_cpu_step_unit.sv]
// ----------------------------------------------------------------------------
// four_register_cpu_step_unit
// Four-register processor core that loads one memory word or runs one
// instruction per command, under a small sequencer around a shared ALU.
// ----------------------------------------------------------------------------
//  channel   | handshake           | payload
//  ----------+---------------------+------------------------------------------
//  command   | start / busy        | i_operation, i_mem_address, i_mem_data,
//            |                     | i_read_value
//  result    | o_done (strobe)     | o_prog_counter, o_halted, o_illegal,
//            |                     | o_read_taken, o_out_valid, o_out_value,
//            |                     | o_status_flags, o_cycle_count
//
//  A memory write word or a step while halted goes from idle to done; an
//  instruction passes fetch, operand, execute and done, a memory load adds a
//  load state, and a call or return moves six stack words, one per cycle.
//  Reset (synchronous, i_rst_n low) clears the registers, status, cost
//  counter and halt flag, sets the stack pointer to 256 and marks every
//  memory word invalid so that it reads as zero; no clearing pass is needed.
//  busy is high from acceptance up to and including the o_done cycle; the
//  result is shown for that one cycle only, and the receiver cannot stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "four_register_cpu_step_unit_macros.svh"

module four_register_cpu_step_unit
    import frcs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output      logic               busy,
    input  wire logic               i_operation,
    input  wire logic [7:0]         i_mem_address,
    input  wire logic signed [31:0] i_mem_data,
    input  wire logic signed [31:0] i_read_value,
    output      logic               o_done,
    output      logic [7:0]         o_prog_counter,
    output      logic               o_halted,
    output      logic               o_illegal,
    output      logic               o_read_taken,
    output      logic               o_out_valid,
    output      logic signed [31:0] o_out_value,
    output      logic [3:0]         o_status_flags,
    output      logic [31:0]        o_cycle_count
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_FETCH = 8'b0000_0010,
        S_OPND  = 8'b0000_0100,
        S_EXEC  = 8'b0000_1000,
        S_LOAD  = 8'b0001_0000,
        S_PUSH  = 8'b0010_0000,
        S_POP   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    // Stack slot numbering: pushes go pc, r0..r3, status; pops the reverse
    localparam logic [2:0] SLOT_FIRST = 3'd0;
    localparam logic [2:0] SLOT_LAST  = 3'd5;
    localparam logic [2:0] POP_END    = 3'd6;
    localparam logic [2:0] POP_BASE   = 3'd5;

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_pc, n_pc;
    logic [SP_W-1:0]     r_sp, n_sp;
    logic [WORD_W-1:0]   r_stat, n_stat;
    logic [WORD_W-1:0]   r_cyc, n_cyc;
    logic                r_halt, n_halt;
    logic [15:0]         r_ir, n_ir;
    logic [WORD_W-1:0]   r_a, n_a;
    logic [WORD_W-1:0]   r_b, n_b;
    logic [ADDR_W-1:0]   r_link, n_link;
    logic [2:0]          r_cnt, n_cnt;
    logic [WORD_W-1:0]   r_rdval, n_rdval;
    logic                r_ill, n_ill;
    logic                r_taken, n_taken;
    logic                r_ov, n_ov;
    logic [WORD_W-1:0]   r_oval, n_oval;
    logic [WORD_W-1:0]   r_regs [4];
    logic [MEM_WORDS-1:0] r_vld;
    logic                r_rd_vld;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [WORD_W-1:0]   ram_wdata, ram_q, mem_word;
    logic                vld_clr;

    logic                reg_we;
    logic [1:0]          reg_widx, reg_ridx;
    logic [WORD_W-1:0]   reg_wdata, reg_rdata;

    logic [4:0]          ir_op;
    logic [1:0]          ir_rd, ir_rs;
    logic                ir_imm;
    logic [ADDR_W-1:0]   ir_addr;
    logic [WORD_W-1:0]   ir_k, alu_b, alu_y;
    t_cmp_flags          alu_cmp;
    logic [2:0]          cnt_m1, pop_idx;

    frcs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MEM_WORDS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    frcs_alu u_alu (
        .i_op    (alu_sel(ir_op)),
        .i_a     (r_a),
        .i_b     (alu_b),
        .i_carry (r_stat[0]),
        .o_y     (alu_y),
        .o_cmp   (alu_cmp)
    );

    // Words never written since reset read as zero
    assign mem_word  = r_rd_vld ? ram_q : '0;
    assign reg_rdata = r_regs[reg_ridx];

    // Decode fields of the held instruction
    assign ir_op   = r_ir[15:11];
    assign ir_rd   = r_ir[10:9];
    assign ir_imm  = r_ir[8];
    assign ir_rs   = r_ir[7:6];
    assign ir_addr = r_ir[7:0];
    assign ir_k    = {{(WORD_W-ADDR_W){r_ir[7]}}, r_ir[7:0]};
    assign alu_b   = ir_imm ? ir_k : r_b;
    assign cnt_m1  = r_cnt - 3'd1;
    assign pop_idx = POP_BASE - r_cnt;

    always_comb begin
        n_state   = r_state;
        n_pc      = r_pc;
        n_sp      = r_sp;
        n_stat    = r_stat;
        n_cyc     = r_cyc;
        n_halt    = r_halt;
        n_ir      = r_ir;
        n_a       = r_a;
        n_b       = r_b;
        n_link    = r_link;
        n_cnt     = r_cnt;
        n_rdval   = r_rdval;
        n_ill     = r_ill;
        n_taken   = r_taken;
        n_ov      = r_ov;
        n_oval    = r_oval;
        ram_we    = 1'b0;
        ram_waddr = ir_addr;
        ram_wdata = r_a;
        ram_raddr = r_pc;
        vld_clr   = 1'b0;
        reg_we    = 1'b0;
        reg_widx  = ir_rd;
        reg_wdata = alu_y;
        reg_ridx  = ir_rd;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    // Clear the per-word flags and latch the read input
                    n_ill   = 1'b0;
                    n_taken = 1'b0;
                    n_ov    = 1'b0;
                    n_oval  = '0;
                    n_rdval = i_read_value;
                    if (!i_operation) begin
                        ram_we    = 1'b1;
                        ram_waddr = i_mem_address;
                        ram_wdata = i_mem_data;
                        n_state   = S_DONE;
                    end else if (r_halt) begin
                        n_state = S_DONE;
                    end else begin
                        ram_raddr = r_pc;
                        n_state   = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                n_ir     = mem_word[15:0];
                reg_ridx = mem_word[10:9];
                n_a      = reg_rdata;
                n_state  = S_OPND;
            end
            S_OPND: begin
                reg_ridx = ir_rs;
                n_b      = reg_rdata;
                n_state  = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_DONE;
                if (ir_op == OP_HALT) begin
                    // Hold the pc on the halt word, add no cost
                    n_halt = 1'b1;
                end else if (!op_known(ir_op)) begin
                    n_ill = 1'b1;
                end else begin
                    n_pc  = r_pc + 8'd1;
                    n_cyc = r_cyc + {{(WORD_W-COST_W){1'b0}}, op_cost(ir_op, ir_imm)};
                    unique case (ir_op)
                        OP_LD: begin
                            if (ir_imm) begin
                                reg_we    = 1'b1;
                                reg_wdata = ir_k;
                            end else begin
                                ram_raddr = ir_addr;
                                n_state   = S_LOAD;
                            end
                        end
                        OP_ST: begin
                            ram_we    = 1'b1;
                            ram_waddr = ir_addr;
                            ram_wdata = r_a;
                        end
                        OP_ADD, OP_ADC, OP_SUB, OP_SBC, OP_AND, OP_XOR,
                        OP_NOT, OP_SHL, OP_ASR: begin
                            reg_we = 1'b1;
                        end
                        OP_CMP: begin
                            n_stat = {r_stat[WORD_W-1:4], alu_cmp.lt, alu_cmp.eq,
                                      alu_cmp.gt, r_stat[0]};
                        end
                        OP_GST: begin
                            reg_we    = 1'b1;
                            reg_wdata = r_stat;
                        end
                        OP_PST: n_stat = r_a;
                        OP_JMP: n_pc = ir_addr;
                        OP_JLT: if (r_stat[3]) n_pc = ir_addr;
                        OP_JEQ: if (r_stat[2]) n_pc = ir_addr;
                        OP_JGT: if (r_stat[1]) n_pc = ir_addr;
                        OP_CALL: begin
                            n_link  = r_pc + 8'd1;
                            n_pc    = ir_addr;
                            n_cnt   = SLOT_FIRST;
                            n_state = S_PUSH;
                        end
                        OP_RET: begin
                            n_cnt   = SLOT_FIRST;
                            n_state = S_POP;
                        end
                        OP_RD: begin
                            reg_we    = 1'b1;
                            reg_wdata = r_rdval;
                            n_taken   = 1'b1;
                        end
                        OP_WR: begin
                            n_ov   = 1'b1;
                            n_oval = r_a;
                        end
                        default: ;
                    endcase
                end
            end
            S_LOAD: begin
                reg_we    = 1'b1;
                reg_wdata = mem_word;
                n_state   = S_DONE;
            end
            S_PUSH: begin
                // Decrement first, then write one stack word
                n_sp      = r_sp - 9'd1;
                ram_we    = 1'b1;
                ram_waddr = n_sp[ADDR_W-1:0];
                reg_ridx  = cnt_m1[1:0];
                if (r_cnt == SLOT_FIRST) begin
                    ram_wdata = {{(WORD_W-ADDR_W){1'b0}}, r_link};
                end else if (r_cnt == SLOT_LAST) begin
                    ram_wdata = r_stat;
                end else begin
                    ram_wdata = reg_rdata;
                end
                if (r_cnt == SLOT_LAST) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            S_POP: begin
                // Issue one read a cycle, take its data on the next
                if (r_cnt != POP_END) begin
                    ram_raddr = r_sp[ADDR_W-1:0];
                    n_sp      = r_sp + 9'd1;
                    vld_clr   = (r_cnt != SLOT_LAST);
                end
                if (r_cnt != SLOT_FIRST) begin
                    if (cnt_m1 == SLOT_FIRST) begin
                        n_stat = mem_word;
                    end else if (cnt_m1 == SLOT_LAST) begin
                        n_pc = mem_word[ADDR_W-1:0];
                    end else begin
                        reg_we    = 1'b1;
                        reg_widx  = pop_idx[1:0];
                        reg_wdata = mem_word;
                    end
                end
                if (r_cnt == POP_END) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pc     <= '0;
            r_sp     <= 9'd256;
            r_stat   <= '0;
            r_cyc    <= '0;
            r_halt   <= 1'b0;
            r_cnt    <= '0;
            r_ill    <= 1'b0;
            r_taken  <= 1'b0;
            r_ov     <= 1'b0;
            r_oval   <= '0;
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_regs[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_pc     <= n_pc;
            r_sp     <= n_sp;
            r_stat   <= n_stat;
            r_cyc    <= n_cyc;
            r_halt   <= n_halt;
            r_cnt    <= n_cnt;
            r_ill    <= n_ill;
            r_taken  <= n_taken;
            r_ov     <= n_ov;
            r_oval   <= n_oval;
            r_rd_vld <= r_vld[ram_raddr];
            if (ram_we) begin
                r_vld[ram_waddr] <= 1'b1;
            end
            if (vld_clr) begin
                r_vld[ram_raddr] <= 1'b0;
            end
            if (reg_we) begin
                r_regs[reg_widx] <= reg_wdata;
            end
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge i_clk) begin
        r_ir    <= n_ir;
        r_a     <= n_a;
        r_b     <= n_b;
        r_link  <= n_link;
        r_rdval <= n_rdval;
    end

    assign busy           = r_state != S_IDLE;
    assign o_done         = r_state == S_DONE;
    assign o_prog_counter = r_pc;
    assign o_halted       = r_halt;
    assign o_illegal      = r_ill;
    assign o_read_taken   = r_taken;
    assign o_out_valid    = r_ov;
    assign o_out_value    = r_oval;
    assign o_status_flags = r_stat[3:0];
    assign o_cycle_count  = r_cyc;

    // A result strobe is always followed by an idle cycle
    `FRCS_CHECK(a_done_then_idle, o_done |=> !busy, "result strobe not followed by idle")
    // A step taken while halted reports at once
    `FRCS_CHECK(a_halted_step, (start && !busy && i_operation && r_halt) |=> o_done, "halted step")
    // An unknown opcode leaves the program counter where it was
    `FRCS_CHECK(a_illegal_pc, (r_state == S_EXEC && ir_op != OP_HALT && !op_known(ir_op)) |=> (r_pc == $past(r_pc)), "unknown opcode moved the pc")
    // Every push cycle moves the stack pointer down by one
    `FRCS_CHECK(a_push_sp, (r_state == S_PUSH) |=> (r_sp == $past(r_sp) - 9'd1), "push did not decrement sp")

endmodule

`default_nettype wire
